// ----- hw/rtl/aft_pkg.sv -----
// shared types and fixed-point constants of the aces fitted tonemap unit
// constants are held in q.24; depends on nothing
package aft_pkg;

    localparam longint Q_ONE = 64'sd16777216;

    localparam int DIV_STEPS  = 26;
    localparam int NUM_STAGES = 35;

    typedef logic        [28:0] t_s;
    typedef logic        [28:0] t_v;
    typedef logic        [23:0] t_m1;
    typedef logic        [52:0] t_p1;
    typedef logic        [58:0] t_nv;
    typedef logic signed [59:0] t_num;
    typedef logic        [29:0] t_inner;
    typedef logic        [35:0] t_den;
    typedef logic        [61:0] t_rem;
    typedef logic        [DIV_STEPS-1:0] t_q;
    typedef logic signed [26:0] t_c;
    typedef logic signed [26:0] t_m2;
    typedef logic signed [53:0] t_p2;

    localparam logic [24:0] K_SCALE = 25'((64'sd18 * Q_ONE + 64'sd5) / 64'sd10);

    localparam t_m1 K_IN_MAT [3][3] = '{
        '{24'((64'sd59719 * Q_ONE + 64'sd50000) / 64'sd100000),
          24'((64'sd35458 * Q_ONE + 64'sd50000) / 64'sd100000),
          24'((64'sd4823  * Q_ONE + 64'sd50000) / 64'sd100000)},
        '{24'((64'sd7600  * Q_ONE + 64'sd50000) / 64'sd100000),
          24'((64'sd90834 * Q_ONE + 64'sd50000) / 64'sd100000),
          24'((64'sd1566  * Q_ONE + 64'sd50000) / 64'sd100000)},
        '{24'((64'sd2840  * Q_ONE + 64'sd50000) / 64'sd100000),
          24'((64'sd13383 * Q_ONE + 64'sd50000) / 64'sd100000),
          24'((64'sd83777 * Q_ONE + 64'sd50000) / 64'sd100000)}
    };

    localparam t_m2 K_OUT_MAT [3][3] = '{
        '{27'( ((64'sd160475 * Q_ONE + 64'sd50000) / 64'sd100000)),
          27'(-((64'sd53108  * Q_ONE + 64'sd50000) / 64'sd100000)),
          27'(-((64'sd7367   * Q_ONE + 64'sd50000) / 64'sd100000))},
        '{27'(-((64'sd10208  * Q_ONE + 64'sd50000) / 64'sd100000)),
          27'( ((64'sd110813 * Q_ONE + 64'sd50000) / 64'sd100000)),
          27'(-((64'sd605    * Q_ONE + 64'sd50000) / 64'sd100000))},
        '{27'(-((64'sd327    * Q_ONE + 64'sd50000) / 64'sd100000)),
          27'(-((64'sd7276   * Q_ONE + 64'sd50000) / 64'sd100000)),
          27'( ((64'sd107602 * Q_ONE + 64'sd50000) / 64'sd100000))}
    };

    localparam logic [29:0] K_C1 =
        30'((64'sd245786 * Q_ONE + 64'sd5000000) / 64'sd10000000);
    localparam logic [59:0] K_C2_SH =
        60'(((64'sd90537 * Q_ONE + 64'sd500000000) / 64'sd1000000000) * Q_ONE);
    localparam logic [23:0] K_D1 =
        24'((64'sd983729 * Q_ONE + 64'sd500000) / 64'sd1000000);
    localparam logic [29:0] K_D2 =
        30'((64'sd4329510 * Q_ONE + 64'sd5000000) / 64'sd10000000);
    localparam logic [59:0] K_D3_SH =
        60'(((64'sd238081 * Q_ONE + 64'sd500000) / 64'sd1000000) * Q_ONE);

endpackage

// ----- hw/rtl/aces_fitted_tonemap_unit.sv -----
// aces fitted tonemap unit: input matrix, rational curve with pipelined divider,
// output matrix and saturation to signed q1.15; depends on aft_pkg
//
// usage:
//  input channel: i_valid / o_ready carry one linear rgb pixel per request,
//  each channel unsigned q4.12 (i_red_in, i_green_in, i_blue_in)
//  output channel: o_valid / i_ready carry one tonemapped pixel per request,
//  each channel signed q1.15 saturated to 17 bits (o_red_out .. o_blue_out)
//  throughput: one pixel per clock while the output is not stalled; the
//  pipeline depth is set by the 26-stage restoring divider, one quotient
//  bit per stage, plus the matrix, curve and rounding stages around it
//  stall: a skid register behind the output register takes one more result
//  while the receiver holds i_ready low; o_ready then drops and the whole
//  pipeline holds, nothing is lost or repeated
//  reset: synchronous, active low; clears all valid bits, payload is not reset
module aces_fitted_tonemap_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_red_in,
    input  logic [15:0]        i_green_in,
    input  logic [15:0]        i_blue_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_red_out,
    output logic signed [16:0] o_green_out,
    output logic signed [16:0] o_blue_out
);

    localparam int NST = aft_pkg::NUM_STAGES;
    localparam int NDV = aft_pkg::DIV_STEPS;

    logic            en;
    logic [NST-1:0]  r_vld;
    logic [15:0]     w_in [3];

    aft_pkg::t_s     r_s    [3];
    aft_pkg::t_p1    r_p1   [3][3];
    aft_pkg::t_v     r_v2   [3];
    aft_pkg::t_nv    r_nv   [3];
    aft_pkg::t_p1    r_dp   [3];
    aft_pkg::t_v     r_v3   [3];
    aft_pkg::t_num   r_num4 [3];
    aft_pkg::t_inner r_inner[3];
    aft_pkg::t_v     r_v4   [3];
    aft_pkg::t_nv    r_ip   [3];
    aft_pkg::t_num   r_num5 [3];
    aft_pkg::t_rem   r_rem  [NDV+1][3];
    aft_pkg::t_den   r_den  [NDV+1][3];
    aft_pkg::t_q     r_q    [NDV+1][3];
    logic            r_sgn  [NDV+1][3];
    aft_pkg::t_c     r_c    [3];
    aft_pkg::t_p2    r_p2   [3][3];

    logic signed [16:0] w_o [3];
    logic signed [16:0] r_o [3];
    logic signed [16:0] r_k [3];
    logic               r_o_vld;
    logic               r_k_vld;
    logic               take;

    assign w_in[0] = i_red_in;
    assign w_in[1] = i_green_in;
    assign w_in[2] = i_blue_in;

    assign en      = ~r_k_vld;
    assign o_ready = en;
    assign o_valid = r_o_vld;
    assign take    = r_o_vld & i_ready;

    assign o_red_out   = r_o[0];
    assign o_green_out = r_o[1];
    assign o_blue_out  = r_o[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // scale, input matrix, curve operands
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_s[j] <= aft_pkg::t_s'(((42'(w_in[j]) * 42'(aft_pkg::K_SCALE))
                          + 42'd2048) >> 12);
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p1[i][j] <= 53'(aft_pkg::K_IN_MAT[i][j]) * 53'(r_s[j]);
                end
                r_v2[i] <= aft_pkg::t_v'((55'(r_p1[i][0]) + 55'(r_p1[i][1])
                           + 55'(r_p1[i][2]) + 55'd8388608) >> 24);
                r_nv[i] <= 59'(30'(r_v2[i]) + aft_pkg::K_C1) * 59'(r_v2[i]);
                r_dp[i] <= 53'(aft_pkg::K_D1) * 53'(r_v2[i]);
                r_v3[i] <= r_v2[i];
                r_num4[i]  <= $signed({1'b0, r_nv[i]}) - $signed(aft_pkg::K_C2_SH);
                r_inner[i] <= 30'((r_dp[i] + 53'd8388608) >> 24) + aft_pkg::K_D2;
                r_v4[i]    <= r_v3[i];
                r_ip[i]    <= 59'(r_inner[i]) * 59'(r_v4[i]);
                r_num5[i]  <= r_num4[i];
            end
        end
    end

    // denominator and rounded dividend magnitude
    always_ff @(posedge i_clk) begin
        aft_pkg::t_den den;
        logic [59:0]   mag;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                den = aft_pkg::t_den'((60'(r_ip[i]) + aft_pkg::K_D3_SH
                      + 60'd8388608) >> 24);
                mag = r_num5[i][59] ? 60'(-r_num5[i]) : 60'(r_num5[i]);
                r_den[0][i] <= den;
                r_rem[0][i] <= aft_pkg::t_rem'(mag) + aft_pkg::t_rem'(den >> 1);
                r_sgn[0][i] <= r_num5[i][59];
                r_q[0][i]   <= '0;
            end
        end
    end

    for (genvar d = 0; d < NDV; d++) begin : g_div
        aft_pkg::t_rem w_sub [3];
        logic          w_ge  [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_sub[i] = aft_pkg::t_rem'(r_den[d][i]) << (NDV - 1 - d);
                w_ge[i]  = r_rem[d][i] >= w_sub[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[d+1][i] <= w_ge[i] ? r_rem[d][i] - w_sub[i] : r_rem[d][i];
                    r_q[d+1][i]   <= {r_q[d][i][NDV-2:0], w_ge[i]};
                    r_den[d+1][i] <= r_den[d][i];
                    r_sgn[d+1][i] <= r_sgn[d][i];
                end
            end
        end
    end

    // signed curve value, output matrix
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= r_sgn[NDV][i] ? -$signed({1'b0, r_q[NDV][i]})
                                        :  $signed({1'b0, r_q[NDV][i]});
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p2[i][j] <= 54'(aft_pkg::K_OUT_MAT[i][j]) * 54'(r_c[j]);
                end
            end
        end
    end

    // sum, round half away from zero, saturate
    always_comb begin
        logic signed [55:0] acc;
        logic [55:0]        mag;
        logic [22:0]        rnd;
        logic signed [23:0] o;
        for (int i = 0; i < 3; i++) begin
            acc = 56'(r_p2[i][0]) + 56'(r_p2[i][1]) + 56'(r_p2[i][2]);
            mag = acc[55] ? 56'(-acc) : 56'(acc);
            rnd = 23'((mag + 56'h1_0000_0000) >> 33);
            o   = acc[55] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
            if (o > 24'sd65535) begin
                w_o[i] = 17'sd65535;
            end else if (o < -24'sd65536) begin
                w_o[i] = -17'sd65536;
            end else begin
                w_o[i] = 17'(o);
            end
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_k_vld <= 1'b0;
        end else if (r_k_vld) begin
            if (take) begin
                r_o     <= r_k;
                r_k_vld <= 1'b0;
            end
        end else if (!r_o_vld || take) begin
            r_o     <= w_o;
            r_o_vld <= r_vld[NST-1];
        end else if (r_vld[NST-1]) begin
            r_k     <= w_o;
            r_k_vld <= 1'b1;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k_vld |-> r_o_vld)
        else $error("skid full while output register empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && r_vld == '0 && o_ready))
        else $error("valid state not cleared by reset");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-3] |-> (r_rem[NDV][0] < aft_pkg::t_rem'(r_den[NDV][0])
                       && r_rem[NDV][1] < aft_pkg::t_rem'(r_den[NDV][1])
                       && r_rem[NDV][2] < aft_pkg::t_rem'(r_den[NDV][2])))
        else $error("divider remainder not below denominator");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r_den[0][0] != '0 && r_den[0][1] != '0 && r_den[0][2] != '0))
        else $error("zero curve denominator");

endmodule

// ----- tb/testbench.sv -----
// testbench for the aces fitted tonemap unit: drives pixels, predicts each
// tonemapped result in fixed point and checks results in order; depends on aft_pkg
`timescale 1ns / 100ps

class tonemap_scoreboard;
    logic signed [16:0] exp_red[$];
    logic signed [16:0] exp_green[$];
    logic signed [16:0] exp_blue[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function longint qc(longint n, longint d);
        return (n * 64'sd16777216 + d / 2) / d;
    endfunction

    function longint rshift(longint x, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (x >= 0) return (x + half) >>> sh;
        return -((-x + half) >>> sh);
    endfunction

    function longint rdiv(longint x, longint d);
        if (x >= 0) return (x + d / 2) / d;
        return -((-x + d / 2) / d);
    endfunction

    function longint curve(longint v);
        longint num, inner, den;
        num = (v + qc(245786, 10000000)) * v - qc(90537, 1000000000) * 64'sd16777216;
        inner = rshift(qc(983729, 1000000) * v, 24) + qc(4329510, 10000000);
        den = rshift(inner * v + qc(238081, 1000000) * 64'sd16777216, 24);
        if (den <= 0) den = 1;
        return rdiv(num, den);
    endfunction

    function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        longint m1[3][3], m2[3][3], s[3], c[3], acc, o;
        logic signed [16:0] res[3];
        m1 = '{'{qc(59719, 100000), qc(35458, 100000), qc(4823, 100000)},
               '{qc(7600, 100000), qc(90834, 100000), qc(1566, 100000)},
               '{qc(2840, 100000), qc(13383, 100000), qc(83777, 100000)}};
        m2 = '{'{qc(160475, 100000), -qc(53108, 100000), -qc(7367, 100000)},
               '{-qc(10208, 100000), qc(110813, 100000), -qc(605, 100000)},
               '{-qc(327, 100000), -qc(7276, 100000), qc(107602, 100000)}};
        s[0] = rshift(longint'(r) * qc(18, 10), 12);
        s[1] = rshift(longint'(g) * qc(18, 10), 12);
        s[2] = rshift(longint'(b) * qc(18, 10), 12);
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m1[i][j] * s[j];
            c[i] = curve(rshift(acc, 24));
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m2[i][j] * c[j];
            o = rshift(acc, 33);
            if (o > 65535) o = 65535;
            if (o < -65536) o = -65536;
            res[i] = o[16:0];
        end
        exp_red.push_back(res[0]);
        exp_green.push_back(res[1]);
        exp_blue.push_back(res[2]);
    endfunction

    function void check_pixel(logic signed [16:0] r, logic signed [16:0] g,
                              logic signed [16:0] b);
        logic signed [16:0] er, eg, eb;
        if (exp_red.size() == 0) begin
            $display("%0t unexpected result %0d %0d %0d", $time, r, g, b);
            errors++;
            return;
        end
        er = exp_red.pop_front();
        eg = exp_green.pop_front();
        eb = exp_blue.pop_front();
        if (r !== er) begin
            $display("%0t red expected %0d actual %0d", $time, er, r);
            errors++;
        end
        if (g !== eg) begin
            $display("%0t green expected %0d actual %0d", $time, eg, g);
            errors++;
        end
        if (b !== eb) begin
            $display("%0t blue expected %0d actual %0d", $time, eb, b);
            errors++;
        end
    endfunction

    function int pending();
        return exp_red.size();
    endfunction
endclass

module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [15:0]        i_red_in;
    logic [15:0]        i_green_in;
    logic [15:0]        i_blue_in;
    logic               o_valid;
    logic               i_ready;
    logic signed [16:0] o_red_out;
    logic signed [16:0] o_green_out;
    logic signed [16:0] o_blue_out;

    tonemap_scoreboard sb;
    int  sent;
    bit  hold_rx;
    bit  calm;

    aces_fitted_tonemap_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(r, g, b);
        sent++;
    endtask

    function automatic logic [15:0] rand_chan();
        unique case ($urandom_range(5))
            0: return 16'($urandom_range(255));
            1: return 16'($urandom_range(4095));
            2: return 16'hffff - 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) sb.check_pixel(o_red_out, o_green_out, o_blue_out);
            i_ready <= !hold_rx && (calm || $urandom_range(99) >= 9);
        end
    end

    initial begin
        logic [15:0] edges[6];
        sb = new();
        edges = '{16'h0000, 16'h0001, 16'h1000, 16'h8000, 16'hfffe, 16'hffff};
        sent = 0; hold_rx = 0; calm = 0;
        i_rst_n = 0; i_valid = 0;
        i_red_in = 0; i_green_in = 0; i_blue_in = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (edges[k]) send_pixel(edges[k], edges[k], edges[k]);
        send_pixel(16'hffff, 0, 0);
        send_pixel(0, 16'hffff, 0);
        send_pixel(0, 0, 16'hffff);
        send_pixel(16'hffff, 16'hffff, 0);
        send_pixel(0, 16'hffff, 16'hffff);
        send_pixel(16'hffff, 0, 16'hffff);
        send_pixel(16'h5555, 16'haaaa, 16'h5555);
        send_pixel(16'haaaa, 16'h5555, 16'haaaa);
        send_pixel(16'h0010, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0010, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0010);
        // sender pause until drained
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // long receiver hold-off, input keeps offering
        fork
            begin
                hold_rx = 1;
                repeat (120) @(posedge i_clk);
                hold_rx = 0;
            end
            for (int n = 0; n < 60; n++) send_pixel(rand_chan(), rand_chan(), rand_chan());
        join
        calm = 1;
        for (int n = 0; n < 150; n++) send_pixel(rand_chan(), rand_chan(), rand_chan());
        calm = 0;
        for (int n = 0; n < 390; n++) send_pixel(rand_chan(), rand_chan(), rand_chan());
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (aft_pkg::NUM_STAGES + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
